// ----- src/aes_pkg.sv -----
// Shared types, tables and byte/word functions for the AES-128 cipher block.
package aes_pkg;

	localparam int unsigned BlkW = 128;
	localparam int unsigned HalfW = 64;
	localparam int unsigned NumRounds = 10;
	localparam int unsigned RndW = 4;
	localparam logic [7:0] RconInit = 8'h01;
	localparam logic [7:0] RconLast = 8'h36;
	localparam logic [7:0] GfReduce = 8'h1b;

	localparam logic CfgKeyHigh = 1'b0;
	localparam logic CfgKeyLow = 1'b1;

	typedef struct packed {
		logic dec;
		logic skip_mix;
	} round_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
		8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
		8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
		8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
		8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
		8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
		8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
		8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
		8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
		8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
		8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
		8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
		8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
		8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
		8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
		8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
		8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
		8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
		8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
		8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
		8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
		8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
		8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
		8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
		8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
		8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
		8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
		8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
		8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
		8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
		8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
		8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? GfReduce : 8'h00);
	endfunction

	// divide by x in GF(2^8), undoes xtime
	function automatic logic [7:0] xdiv(input logic [7:0] b);
		logic [7:0] t;
		t = b[0] ? (b ^ GfReduce) : b;
		xdiv = {b[0], t[7:1]};
	endfunction

	function automatic logic [31:0] sub_rot(input logic [31:0] w);
		sub_rot = {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
	endfunction

	function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3;
		w0 = k[127:96] ^ sub_rot(k[31:0]) ^ {rc, 24'h0};
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		key_fwd = {w0, w1, w2, w3};
	endfunction

	function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] p0, p1, p2, p3;
		p3 = k[31:0] ^ k[63:32];
		p2 = k[63:32] ^ k[95:64];
		p1 = k[95:64] ^ k[127:96];
		p0 = k[127:96] ^ sub_rot(p3) ^ {rc, 24'h0};
		key_inv = {p0, p1, p2, p3};
	endfunction

endpackage

// ----- src/aes_lane.sv -----
// One column lane: S-box and MixColumns forward, or inverse MixColumns and inverse S-box; the mix can be skipped.
module aes_lane (
	input  logic [31:0]            col,
	input  aes_pkg::round_ctl_t    ctl,
	output logic [31:0]            res
);
	logic [7:0] a [4];
	logic [7:0] s [4];
	logic [7:0] m [4];
	logic [7:0] x1 [4];
	logic [7:0] x2 [4];
	logic [7:0] x4 [4];
	logic [7:0] x8 [4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			a[r] = col[31 - 8 * r -: 8];
			s[r] = aes_pkg::SBOX[a[r]];
		end
		for (int r = 0; r < 4; r++) begin
			x1[r] = ctl.dec ? a[r] : s[r];
			x2[r] = aes_pkg::xtime(x1[r]);
			x4[r] = aes_pkg::xtime(x2[r]);
			x8[r] = aes_pkg::xtime(x4[r]);
		end
		for (int r = 0; r < 4; r++) begin
			if (!ctl.dec) begin
				m[r] = x2[r] ^ x2[(r + 1) % 4] ^ x1[(r + 1) % 4] ^ x1[(r + 2) % 4]
					^ x1[(r + 3) % 4];
			end else begin
				m[r] = (x8[r] ^ x4[r] ^ x2[r])
					^ (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ x1[(r + 1) % 4])
					^ (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ x1[(r + 2) % 4])
					^ (x8[(r + 3) % 4] ^ x1[(r + 3) % 4]);
			end
			if (ctl.skip_mix) begin
				m[r] = x1[r];
			end
			res[31 - 8 * r -: 8] = ctl.dec ? aes_pkg::INV_SBOX[m[r]] : m[r];
		end
	end
endmodule

// ----- src/aes_round.sv -----
// One full round: four column lanes, row shift merge and round key add.
module aes_round (
	input  logic [127:0]           st,
	input  logic [127:0]           rk,
	input  aes_pkg::round_ctl_t    ctl,
	output logic [127:0]           res
);
	logic [7:0]   sb [16];
	logic [127:0] pre;
	logic [127:0] lane_out;
	logic [7:0]   lb [16];
	logic [127:0] post;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			sb[i] = st[127 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				pre[127 - 8 * (4 * c + r) -: 8] =
					ctl.dec ? sb[4 * c + r] : sb[4 * ((c + r) % 4) + r];
			end
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_lane
		aes_lane u_lane (
			.col (pre[127 - 32 * c -: 32]),
			.ctl (ctl),
			.res (lane_out[127 - 32 * c -: 32])
		);
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			lb[i] = lane_out[127 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				post[127 - 8 * (4 * c + r) -: 8] =
					ctl.dec ? lb[4 * ((c + 4 - r) % 4) + r] : lb[4 * c + r];
			end
		end
		res = post ^ rk;
	end
endmodule

// ----- src/aes128_block_cipher_top.sv -----
// Top level of the AES-128 encrypt/decrypt block with key schedule sequencer.
//  channel | handshake             | payload
//  cfg     | cfg_we                | cfg_idx, cfg_data
//  in      | in_valid / in_stall   | req_type, block_high, block_low
//  out     | out_valid / out_stall | result_high, result_low
// One block runs the ten AES rounds in the shared round unit after the accept beat;
// the round key is stepped alongside, forward or backward.
// A key write taken when idle or expanding (and reset) runs an expansion for the last round key;
// a write during it restarts it. in_stall is high during it. Results sit in an output
// register; the next beat is taken once the running block has been handed to it.
module aes128_block_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXPAND = 4'b0010,
		ST_RUN    = 4'b0100,
		ST_HOLD   = 4'b1000
	} state_t;

	state_t       state_q;
	logic [127:0] key_q;
	logic [127:0] rk10_q;
	logic [127:0] rk_q;
	logic [127:0] st_q;
	logic [7:0]   rcon_q;
	logic [3:0]   rnd_q;
	logic         dec_q;
	logic         out_valid_q;
	logic [127:0] out_q;

	logic                 in_acc;
	logic                 out_free;
	logic                 out_load;
	logic                 cfg_take;
	logic                 last_rnd;
	logic [127:0]         rk_next;
	logic [127:0]         round_res;
	aes_pkg::round_ctl_t  ctl;

	assign in_stall = (state_q != ST_IDLE) || cfg_we;
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign last_rnd = (rnd_q == 4'(aes_pkg::NumRounds));
	assign out_load = out_free && ((state_q == ST_RUN && last_rnd) || state_q == ST_HOLD);
	assign cfg_take = cfg_we && (state_q == ST_IDLE || state_q == ST_EXPAND);
	assign rk_next = (dec_q && state_q == ST_RUN) ? aes_pkg::key_inv(rk_q, rcon_q)
		: aes_pkg::key_fwd(rk_q, rcon_q);
	assign ctl = '{dec: dec_q, skip_mix: (dec_q ? (rnd_q == 4'd1) : last_rnd)};

	aes_round u_round (
		.st  (st_q),
		.rk  (rk_next),
		.ctl (ctl),
		.res (round_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXPAND;
			key_q <= '0;
			rk_q <= '0;
			rcon_q <= aes_pkg::RconInit;
			rnd_q <= 4'd1;
			dec_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_q <= (state_q == ST_HOLD) ? st_q : round_res;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_take) begin
				state_q <= ST_EXPAND;
				rnd_q <= 4'd1;
				rcon_q <= aes_pkg::RconInit;
				dec_q <= 1'b0;
				if (cfg_idx == aes_pkg::CfgKeyHigh) begin
					key_q[127:64] <= cfg_data;
					rk_q <= {cfg_data, key_q[63:0]};
				end else begin
					key_q[63:0] <= cfg_data;
					rk_q <= {key_q[127:64], cfg_data};
				end
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (in_acc) begin
							state_q <= ST_RUN;
							rnd_q <= 4'd1;
							dec_q <= req_type;
							rcon_q <= req_type ? aes_pkg::RconLast : aes_pkg::RconInit;
							rk_q <= req_type ? rk10_q : key_q;
							st_q <= {block_high, block_low} ^ (req_type ? rk10_q : key_q);
						end
					end
					ST_EXPAND: begin
						rk_q <= rk_next;
						rcon_q <= aes_pkg::xtime(rcon_q);
						rnd_q <= rnd_q + 4'd1;
						if (last_rnd) begin
							rk10_q <= rk_next;
							state_q <= ST_IDLE;
						end
					end
					ST_RUN: begin
						rk_q <= rk_next;
						rcon_q <= dec_q ? aes_pkg::xdiv(rcon_q) : aes_pkg::xtime(rcon_q);
						rnd_q <= rnd_q + 4'd1;
						st_q <= round_res;
						if (last_rnd) begin
							state_q <= out_free ? ST_IDLE : ST_HOLD;
						end
					end
					ST_HOLD: begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result_high = out_q[127:64];
	assign result_low = out_q[63:0];
endmodule

// ----- src/aes_checker.sv -----
// Port-level checks for the AES-128 cipher top level, bound to it.
module aes_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] result_high,
	input logic [63:0] result_low
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_high) && $stable(result_low))
		else $error("output beat dropped or changed while stalled");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a block is in flight");

	a_busy_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input open during key expansion");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 !$rose(out_valid))
		else $error("result appeared too soon after input beat");
endmodule

bind aes128_block_cipher_top aes_checker u_aes_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_high (result_high),
	.result_low  (result_low)
);
